/* hdl/imuocs_pkg.sv */
// Shared types, constants and helper functions for the IMU offset calibrate and scale unit.
// Used by every module under hdl/; depends on nothing else.

package imuocs_pkg;

    // Raw sample width that is actually used from each 16-bit field, and axes in use.
    localparam int RAW_WIDTH = 16;
    localparam int AXES      = 3;

    // Fixed field widths.
    localparam int FIELD_W   = 16;
    localparam int SUM_W     = 25;
    localparam int CNT_W     = 8;
    localparam int ACCEL_W   = 20;
    localparam int GYRO_W    = 21;
    localparam int TEMP_W    = 15;
    localparam int SLOTS     = 3;

    // Stream payload widths.
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 144;

    // Divider: magnitude of a 25-bit signed sum fits in 24 bits, one bit per step.
    localparam int DIV_STEPS = SUM_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Gyro scaling: round(n / 131) by reciprocal, M = floor(2^36 / 131).
    localparam int          GYRO_N_W     = 28;
    localparam int          GYRO_SHIFT   = 36;
    localparam logic [28:0] GYRO_RECIP   = 29'd524576158;
    localparam logic [7:0]  GYRO_DIVISOR = 8'd131;
    localparam logic [7:0]  GYRO_HALF    = 8'd65;
    localparam logic [3:0]  GYRO_BASE_SH = 4'd8;

    // Temperature: round(t * 5 / 17) + 3653, reciprocal M = floor(2^24 / 17).
    localparam int          TEMP_N_W     = 18;
    localparam int          TEMP_SHIFT   = 24;
    localparam logic [19:0] TEMP_RECIP   = 20'd986895;
    localparam logic [4:0]  TEMP_DIVISOR = 5'd17;
    localparam logic [3:0]  TEMP_HALF    = 4'd8;
    localparam logic [2:0]  TEMP_MULT    = 3'd5;
    localparam logic signed [TEMP_W-1:0] TEMP_BIAS = 15'sd3653;

    // Configuration register indexes (byte address = 4 * index).
    localparam int         CFG_ADDR_W         = 5;
    localparam logic [2:0] REG_GYRO_RANGE     = 3'd0;
    localparam logic [2:0] REG_ACCEL_RANGE    = 3'd1;
    localparam logic [2:0] REG_CALIB_SAMPLES  = 3'd2;
    localparam logic [2:0] REG_ACCEL_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_ACCEL_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_ACCEL_OFFSET_Z = 3'd5;
    localparam logic [CNT_W-1:0] CALIB_SAMPLES_RESET = 8'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_COMMIT,
        ST_MUL,
        ST_FIX,
        ST_OUT
    } state_t;

    // Per-phase strobes from the sequencer to the lanes and the temperature unit.
    typedef struct packed {
        logic accum;
        logic calib;
        logic div_step;
        logic commit;
        logic mul;
        logic fix;
    } lane_ctrl_t;

    // Keeps the low RAW_WIDTH bits of a field and sign-extends them.
    function automatic logic signed [FIELD_W-1:0] sext_raw(input logic [FIELD_W-1:0] v);
        logic signed [RAW_WIDTH-1:0] t;
        t = v[RAW_WIDTH-1:0];
        return FIELD_W'(t);
    endfunction

endpackage

/* hdl/imuocs_lane.sv */
// One axis lane: gyro sum and offset, iterative offset divider, accel and gyro scaling.
// Depends on imuocs_pkg.

module imuocs_lane (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  imuocs_pkg::lane_ctrl_t                  ctrl,
    input  logic [1:0]                              gyro_range,
    input  logic [1:0]                              accel_range,
    input  logic signed [imuocs_pkg::FIELD_W-1:0]   raw_gyro,
    input  logic signed [imuocs_pkg::FIELD_W-1:0]   raw_accel,
    input  logic signed [imuocs_pkg::FIELD_W-1:0]   acc_bias,
    input  logic [imuocs_pkg::CNT_W-1:0]            divisor,
    output logic signed [imuocs_pkg::ACCEL_W-1:0]   accel_scaled,
    output logic signed [imuocs_pkg::GYRO_W-1:0]    gyro_scaled
);

    logic signed [imuocs_pkg::SUM_W-1:0]     sum_reg;
    logic signed [imuocs_pkg::FIELD_W-1:0]   offset_reg;
    logic [imuocs_pkg::DIV_STEPS-1:0]        dvd_reg;
    logic [imuocs_pkg::CNT_W-1:0]            rem_reg;
    logic                                    div_neg_reg;

    logic [imuocs_pkg::GYRO_N_W-1:0]         n_reg;
    logic [imuocs_pkg::GYRO_W-1:0]           q0_reg;
    logic                                    g_neg_reg;
    logic signed [imuocs_pkg::ACCEL_W-1:0]   accel_res_reg;
    logic signed [imuocs_pkg::GYRO_W-1:0]    gyro_res_reg;

    logic signed [imuocs_pkg::SUM_W-1:0]     sum_new;
    logic [imuocs_pkg::SUM_W-1:0]            sum_mag;
    logic [imuocs_pkg::CNT_W:0]              rem_shift;
    logic                                    rem_ge;
    logic [imuocs_pkg::CNT_W:0]              rem_sub;
    logic signed [imuocs_pkg::FIELD_W:0]     gdiff;
    logic [imuocs_pkg::FIELD_W:0]            gmag;
    logic [imuocs_pkg::GYRO_N_W-1:0]         n_val;
    logic [56:0]                             prod;
    logic [28:0]                             r_val;
    logic [imuocs_pkg::GYRO_W-1:0]           q_val;
    logic signed [imuocs_pkg::FIELD_W:0]     adiff;

    // Sum after adding this sample, and its magnitude for the divider.
    assign sum_new = sum_reg + imuocs_pkg::SUM_W'(raw_gyro);
    assign sum_mag = sum_new[imuocs_pkg::SUM_W-1] ? imuocs_pkg::SUM_W'(-sum_new)
                                                 : imuocs_pkg::SUM_W'(sum_new);

    // Restoring division step: one quotient bit per cycle.
    assign rem_shift = {rem_reg, dvd_reg[imuocs_pkg::DIV_STEPS-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    // Gyro: |raw - offset| * 2^(8 + range) + 65, then times the reciprocal of 131.
    assign gdiff = (imuocs_pkg::FIELD_W+1)'(raw_gyro) - (imuocs_pkg::FIELD_W+1)'(offset_reg);
    assign gmag  = gdiff[imuocs_pkg::FIELD_W] ? (imuocs_pkg::FIELD_W+1)'(-gdiff)
                                               : (imuocs_pkg::FIELD_W+1)'(gdiff);
    assign n_val = (imuocs_pkg::GYRO_N_W'(gmag[imuocs_pkg::FIELD_W-1:0])
                    << (imuocs_pkg::GYRO_BASE_SH + 4'(gyro_range)))
                   + imuocs_pkg::GYRO_N_W'(imuocs_pkg::GYRO_HALF);
    assign prod  = 57'(n_val) * 57'(imuocs_pkg::GYRO_RECIP);

    // The reciprocal estimate is exact or one low; one compare fixes it.
    assign r_val = {1'b0, n_reg} - 29'(q0_reg) * 29'(imuocs_pkg::GYRO_DIVISOR);
    assign q_val = (r_val >= 29'(imuocs_pkg::GYRO_DIVISOR)) ? q0_reg + 1'b1 : q0_reg;

    assign adiff = (imuocs_pkg::FIELD_W+1)'(raw_accel) - (imuocs_pkg::FIELD_W+1)'(acc_bias);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end else begin
            if (ctrl.accum) begin
                if (ctrl.calib) begin
                    sum_reg <= '0;
                end else begin
                    sum_reg <= sum_new;
                end
            end
            if (ctrl.commit) begin
                offset_reg <= div_neg_reg ? imuocs_pkg::FIELD_W'(-dvd_reg)
                                          : imuocs_pkg::FIELD_W'(dvd_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accum && ctrl.calib) begin
            dvd_reg     <= sum_mag[imuocs_pkg::DIV_STEPS-1:0];
            rem_reg     <= '0;
            div_neg_reg <= sum_new[imuocs_pkg::SUM_W-1];
        end else if (ctrl.div_step) begin
            dvd_reg <= {dvd_reg[imuocs_pkg::DIV_STEPS-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[imuocs_pkg::CNT_W-1:0]
                              : rem_shift[imuocs_pkg::CNT_W-1:0];
        end
        if (ctrl.mul) begin
            n_reg         <= n_val;
            q0_reg        <= imuocs_pkg::GYRO_W'(prod >> imuocs_pkg::GYRO_SHIFT);
            g_neg_reg     <= gdiff[imuocs_pkg::FIELD_W];
            accel_res_reg <= imuocs_pkg::ACCEL_W'(adiff) <<< accel_range;
        end
        if (ctrl.fix) begin
            gyro_res_reg <= g_neg_reg ? imuocs_pkg::GYRO_W'(-q_val) : imuocs_pkg::GYRO_W'(q_val);
        end
    end

    assign accel_scaled = accel_res_reg;
    assign gyro_scaled  = gyro_res_reg;

endmodule

/* hdl/imuocs_temp.sv */
// Temperature conversion to centi-degrees: round(t * 5 / 17) + 3653, in two steps.
// Depends on imuocs_pkg.

module imuocs_temp (
    input  logic                                   aclk,
    input  imuocs_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [imuocs_pkg::FIELD_W-1:0]  raw_temp,
    output logic signed [imuocs_pkg::TEMP_W-1:0]   temp_centi
);

    logic [imuocs_pkg::TEMP_N_W-1:0]        n_reg;
    logic [13:0]                            q0_reg;
    logic                                   neg_reg;
    logic signed [imuocs_pkg::TEMP_W-1:0]   res_reg;

    logic [imuocs_pkg::FIELD_W:0]           mag;
    logic [imuocs_pkg::TEMP_N_W-1:0]        n_val;
    logic [37:0]                            prod;
    logic [imuocs_pkg::TEMP_N_W-1:0]        r_val;
    logic [13:0]                            q_val;
    logic signed [imuocs_pkg::TEMP_W-1:0]   q_signed;

    assign mag   = raw_temp[imuocs_pkg::FIELD_W-1]
                   ? (imuocs_pkg::FIELD_W+1)'(-(imuocs_pkg::FIELD_W+1)'(raw_temp))
                   : (imuocs_pkg::FIELD_W+1)'(raw_temp);
    assign n_val = imuocs_pkg::TEMP_N_W'(mag) * imuocs_pkg::TEMP_N_W'(imuocs_pkg::TEMP_MULT)
                   + imuocs_pkg::TEMP_N_W'(imuocs_pkg::TEMP_HALF);
    assign prod  = 38'(n_val) * 38'(imuocs_pkg::TEMP_RECIP);

    assign r_val    = n_reg - imuocs_pkg::TEMP_N_W'(q0_reg)
                            * imuocs_pkg::TEMP_N_W'(imuocs_pkg::TEMP_DIVISOR);
    assign q_val    = (r_val >= imuocs_pkg::TEMP_N_W'(imuocs_pkg::TEMP_DIVISOR))
                      ? q0_reg + 1'b1 : q0_reg;
    assign q_signed = neg_reg ? -imuocs_pkg::TEMP_W'(q_val) : imuocs_pkg::TEMP_W'(q_val);

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            n_reg   <= n_val;
            q0_reg  <= 14'(prod >> imuocs_pkg::TEMP_SHIFT);
            neg_reg <= raw_temp[imuocs_pkg::FIELD_W-1];
        end
        if (ctrl.fix) begin
            res_reg <= q_signed + imuocs_pkg::TEMP_BIAS;
        end
    end

    assign temp_centi = res_reg;

endmodule

/* hdl/imu_offset_calibrate_and_scale_unit.sv */
// Top level of the IMU offset calibrate and scale unit: stream ports, APB registers,
// sequencer, three axis lanes, temperature unit and the merging output register.
// Depends on imuocs_pkg, imuocs_lane and imuocs_temp.
// Flow: an accepted input transaction passes the ACCUM, MUL, FIX and OUT states before
// m_tvalid; an item that completes a calibration also passes DIV (the 24-step offset
// division in each lane) and COMMIT. No new item is taken while one is in flight; the next
// input is taken as soon as the current result sits in the output register.
// Reset (aresetn low, synchronous): sums, offsets and sample count cleared, registers to
// their defaults (calib_samples = 64), output register emptied, s_tready held low.

module imu_offset_calibrate_and_scale_unit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Input stream.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // tdata from bit 0: raw_accel_x, raw_accel_y, raw_accel_z, raw_temp,
    // raw_gyro_x, raw_gyro_y, raw_gyro_z (16 bits each).
    input  logic [imuocs_pkg::S_TDATA_W-1:0]          s_tdata,
    // tuser bit 0: func.
    input  logic [0:0]                                s_tuser,
    // Result stream.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // tdata from bit 0: accel_x_scaled, accel_y_scaled, accel_z_scaled (20 bits each),
    // temp_centi (15), gyro_x_scaled, gyro_y_scaled, gyro_z_scaled (21 each), 6 zero bits.
    output logic [imuocs_pkg::M_TDATA_W-1:0]          m_tdata,
    // tuser bit 0: calib_done.
    output logic [0:0]                                m_tuser,
    // Configuration port.
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [imuocs_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands when psel, penable, pwrite and
    // pready are high; addresses above the last register are ignored.
    // ------------------------------------------------------------------
    logic [1:0]                              gyro_range_reg;
    logic [1:0]                              accel_range_reg;
    logic [imuocs_pkg::CNT_W-1:0]            calib_samples_reg;
    logic signed [imuocs_pkg::FIELD_W-1:0]   accel_off_reg [imuocs_pkg::SLOTS];

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_range_reg    <= '0;
            accel_range_reg   <= '0;
            calib_samples_reg <= imuocs_pkg::CALIB_SAMPLES_RESET;
            for (int i = 0; i < imuocs_pkg::SLOTS; i++) begin
                accel_off_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (paddr[imuocs_pkg::CFG_ADDR_W-1:2])
                imuocs_pkg::REG_GYRO_RANGE:     gyro_range_reg    <= pwdata[1:0];
                imuocs_pkg::REG_ACCEL_RANGE:    accel_range_reg   <= pwdata[1:0];
                imuocs_pkg::REG_CALIB_SAMPLES:  calib_samples_reg <= pwdata[7:0];
                imuocs_pkg::REG_ACCEL_OFFSET_X: accel_off_reg[0]  <= pwdata[15:0];
                imuocs_pkg::REG_ACCEL_OFFSET_Y: accel_off_reg[1]  <= pwdata[15:0];
                imuocs_pkg::REG_ACCEL_OFFSET_Z: accel_off_reg[2]  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Reads return the register value; offsets come back sign-extended.
    always_comb begin
        case (paddr[imuocs_pkg::CFG_ADDR_W-1:2])
            imuocs_pkg::REG_GYRO_RANGE:     prdata = 32'(gyro_range_reg);
            imuocs_pkg::REG_ACCEL_RANGE:    prdata = 32'(accel_range_reg);
            imuocs_pkg::REG_CALIB_SAMPLES:  prdata = 32'(calib_samples_reg);
            imuocs_pkg::REG_ACCEL_OFFSET_X: prdata = 32'(accel_off_reg[0]);
            imuocs_pkg::REG_ACCEL_OFFSET_Y: prdata = 32'(accel_off_reg[1]);
            imuocs_pkg::REG_ACCEL_OFFSET_Z: prdata = 32'(accel_off_reg[2]);
            default:                        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input capture. The item is held here for the whole computation, so the
    // input side is free only while the sequencer is idle.
    // ------------------------------------------------------------------
    imuocs_pkg::state_t state_reg, state_next;

    logic                                    func_reg;
    logic signed [imuocs_pkg::FIELD_W-1:0]   raw_accel_reg [imuocs_pkg::SLOTS];
    logic signed [imuocs_pkg::FIELD_W-1:0]   raw_gyro_reg  [imuocs_pkg::SLOTS];
    logic signed [imuocs_pkg::FIELD_W-1:0]   raw_temp_reg;
    logic                                    s_accept;

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg     <= s_tuser[0];
            raw_temp_reg <= imuocs_pkg::sext_raw(s_tdata[63:48]);
            for (int i = 0; i < imuocs_pkg::SLOTS; i++) begin
                raw_accel_reg[i] <= imuocs_pkg::sext_raw(s_tdata[16*i +: 16]);
                raw_gyro_reg[i]  <= imuocs_pkg::sext_raw(s_tdata[64 + 16*i +: 16]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Calibration sample counter. A calibration item bumps the count; when
    // it reaches the target (zero counts as one), every lane divides its sum
    // by the number of samples actually taken and the count restarts.
    // ------------------------------------------------------------------
    logic [imuocs_pkg::CNT_W-1:0]     count_reg;
    logic [imuocs_pkg::CNT_W-1:0]     divisor_reg;
    logic                             done_reg;
    logic [imuocs_pkg::DIV_CNT_W-1:0] step_reg;
    logic [imuocs_pkg::CNT_W:0]       count_inc;
    logic [imuocs_pkg::CNT_W-1:0]     target;
    logic                             calib_hit;
    logic                             in_accum;

    assign count_inc = (imuocs_pkg::CNT_W+1)'(count_reg) + 1'b1;
    assign target    = (calib_samples_reg == '0) ? imuocs_pkg::CNT_W'(1) : calib_samples_reg;
    assign calib_hit = func_reg && (count_inc >= (imuocs_pkg::CNT_W+1)'(target));
    assign in_accum  = (state_reg == imuocs_pkg::ST_ACCUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_accum && func_reg) begin
            count_reg <= calib_hit ? '0 : count_inc[imuocs_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accum) begin
            divisor_reg <= count_inc[imuocs_pkg::CNT_W-1:0];
            done_reg    <= calib_hit;
            step_reg    <= '0;
        end else if (state_reg == imuocs_pkg::ST_DIV) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. The input is closed while reset is held, so no transaction
    // can be taken at an edge that clears the datapath.
    // ------------------------------------------------------------------
    imuocs_pkg::lane_ctrl_t ctrl;
    logic                   out_free;
    logic                   out_load;

    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imuocs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            imuocs_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = imuocs_pkg::ST_ACCUM;
                end
            end
            imuocs_pkg::ST_ACCUM: begin
                ctrl.accum = func_reg;
                ctrl.calib = calib_hit;
                state_next = calib_hit ? imuocs_pkg::ST_DIV : imuocs_pkg::ST_MUL;
            end
            imuocs_pkg::ST_DIV: begin
                ctrl.div_step = 1'b1;
                if (step_reg == imuocs_pkg::DIV_CNT_W'(imuocs_pkg::DIV_STEPS - 1)) begin
                    state_next = imuocs_pkg::ST_COMMIT;
                end
            end
            imuocs_pkg::ST_COMMIT: begin
                ctrl.commit = 1'b1;
                state_next  = imuocs_pkg::ST_MUL;
            end
            imuocs_pkg::ST_MUL: begin
                ctrl.mul   = 1'b1;
                state_next = imuocs_pkg::ST_FIX;
            end
            imuocs_pkg::ST_FIX: begin
                ctrl.fix   = 1'b1;
                state_next = imuocs_pkg::ST_OUT;
            end
            imuocs_pkg::ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = imuocs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = imuocs_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Axis lanes and the temperature unit. Axes beyond AXES give zero.
    // ------------------------------------------------------------------
    logic signed [imuocs_pkg::ACCEL_W-1:0] accel_res [imuocs_pkg::SLOTS];
    logic signed [imuocs_pkg::GYRO_W-1:0]  gyro_res  [imuocs_pkg::SLOTS];
    logic signed [imuocs_pkg::TEMP_W-1:0]  temp_res;

    for (genvar i = 0; i < imuocs_pkg::SLOTS; i++) begin : g_axis
        if (i < imuocs_pkg::AXES) begin : g_lane
            imuocs_lane u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .gyro_range   (gyro_range_reg),
                .accel_range  (accel_range_reg),
                .raw_gyro     (raw_gyro_reg[i]),
                .raw_accel    (raw_accel_reg[i]),
                .acc_bias     (accel_off_reg[i]),
                .divisor      (divisor_reg),
                .accel_scaled (accel_res[i]),
                .gyro_scaled  (gyro_res[i])
            );
        end else begin : g_unused
            assign accel_res[i] = '0;
            assign gyro_res[i]  = '0;
        end
    end

    imuocs_temp u_temp (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .raw_temp   (raw_temp_reg),
        .temp_centi (temp_res)
    );

    // ------------------------------------------------------------------
    // Merge into the output register. It holds one finished result while the
    // next item is accepted and computed.
    // ------------------------------------------------------------------
    logic                               m_tvalid_reg;
    logic [imuocs_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic                               m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'b0, gyro_res[2], gyro_res[1], gyro_res[0], temp_res,
                            accel_res[2], accel_res[1], accel_res[0]};
            m_tuser_reg <= done_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

/* hdl/imuocs_checker.sv */
// Port-level checker for the IMU offset calibrate and scale unit, with its bind statement.
// Depends on imuocs_pkg and on the top level's port list.

module imuocs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [imuocs_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                          m_tuser
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An accepted item keeps the input closed while the sequencer works through the states that follow.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened while an item is in flight");

    // A new result is loaded only as the sequencer returns to idle.
    a_load_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded while input still blocked");

endmodule

bind imu_offset_calibrate_and_scale_unit imuocs_checker u_imuocs_checker (.*);

/* tb/tb.sv */
// Testbench for imu_offset_calibrate_and_scale_unit. It streams raw IMU sample sets through
// the unit under several register settings and checks each scaled result transaction.
// Depends on imuocs_pkg and the RTL under hdl/.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Meaning of the func bit carried in s_tuser.
    localparam logic FUNC_CONVERT   = 1'b0;
    localparam logic FUNC_CALIBRATE = 1'b1;

    localparam logic [15:0] RAW_MAX = 16'h7FFF;
    localparam logic [15:0] RAW_MIN = 16'h8000;

    // Cycles the receiver refuses results when the long hold-off is requested.
    localparam int LONG_STALL  = 300;
    // Settling time after the last result; longer than the calibration path through the unit.
    localparam int IDLE_MARGIN = 40;

    // One raw sample set. The low 112 bits follow the s_tdata layout.
    typedef struct packed {
        logic               func;
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] temp;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } imu_raw_t;

    // One scaled result as the unit should deliver it.
    typedef struct packed {
        logic                                  calib_done;
        logic signed [imuocs_pkg::GYRO_W-1:0]  gyro_z;
        logic signed [imuocs_pkg::GYRO_W-1:0]  gyro_y;
        logic signed [imuocs_pkg::GYRO_W-1:0]  gyro_x;
        logic signed [imuocs_pkg::TEMP_W-1:0]  temp_centi;
        logic signed [imuocs_pkg::ACCEL_W-1:0] accel_z;
        logic signed [imuocs_pkg::ACCEL_W-1:0] accel_y;
        logic signed [imuocs_pkg::ACCEL_W-1:0] accel_x;
    } imu_scaled_t;

    // Every input of the unit holds a known value from time zero on.
    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // s_tdata from bit 0: raw_accel_x, raw_accel_y, raw_accel_z, raw_temp,
    // raw_gyro_x, raw_gyro_y, raw_gyro_z (16 bits each).
    logic [imuocs_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    // s_tuser bit 0: func.
    logic [0:0]                        s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // m_tdata from bit 0: accel_x/y/z_scaled (20 each), temp_centi (15),
    // gyro_x/y/z_scaled (21 each), 6 zero bits.
    logic [imuocs_pkg::M_TDATA_W-1:0]  m_tdata;
    // m_tuser bit 0: calib_done.
    logic [0:0]                        m_tuser;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [imuocs_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]                       pwdata   = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    // Shadow copy of the registers, updated as each APB write completes.
    int     reg_gyro_range      = 0;
    int     reg_accel_range     = 0;
    int     reg_calib_samples   = imuocs_pkg::CALIB_SAMPLES_RESET;
    longint reg_acc_bias[3]     = '{0, 0, 0};

    // Calibration state as the unit should hold it after each accepted transaction.
    longint run_sum[3]   = '{0, 0, 0};
    longint gyro_bias[3] = '{0, 0, 0};
    int     samples_taken = 0;

    // Raw sets waiting for the driver, and scaled results still owed by the unit.
    imu_raw_t    raw_sets_queued[$];
    imu_scaled_t scaled_due[$];

    // Idle percentages for both sides, and the long receiver hold-off handshake.
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stalls_served  = 0;
    int stall_left     = 0;

    imu_raw_t offered;
    int       bad_results = 0;

    imu_offset_calibrate_and_scale_unit DUT (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // A raw reading is the low RAW_WIDTH bits of its field, sign-extended.
    function automatic longint raw_reading(input logic [15:0] field);
        logic signed [15:0] t;
        t = field << (16 - imuocs_pkg::RAW_WIDTH);
        return longint'(t >>> (16 - imuocs_pkg::RAW_WIDTH));
    endfunction

    // Rounds num/den to nearest; den is odd, so halves never occur.
    function automatic longint div_nearest(input longint num, input longint den);
        if (num < 0) return -((-num + den / 2) / den);
        return (num + den / 2) / den;
    endfunction

    // Advances the calibration state by one sample set and returns its scaled result.
    // Offsets updated by this very set already apply to its own scaling.
    function automatic imu_scaled_t convert_sample(input imu_raw_t raw);
        longint      acc[3];
        longint      gyr[3];
        longint      acc_out[3];
        longint      gyr_out[3];
        longint      t_raw;
        int          goal;
        imu_scaled_t r;
        acc[0] = raw_reading(raw.accel_x);
        acc[1] = raw_reading(raw.accel_y);
        acc[2] = raw_reading(raw.accel_z);
        gyr[0] = raw_reading(raw.gyro_x);
        gyr[1] = raw_reading(raw.gyro_y);
        gyr[2] = raw_reading(raw.gyro_z);
        t_raw  = raw_reading(raw.temp);
        r = '0;
        if (raw.func == FUNC_CALIBRATE) begin
            for (int i = 0; i < imuocs_pkg::AXES; i++) run_sum[i] += gyr[i];
            samples_taken = (samples_taken + 1) % 256;
            // A sample count of zero behaves as one. A count lowered below the samples
            // already taken finishes on the next sample, dividing by what was taken.
            goal = (reg_calib_samples == 0) ? 1 : reg_calib_samples;
            if (samples_taken >= goal) begin
                for (int i = 0; i < 3; i++) begin
                    if (i < imuocs_pkg::AXES) gyro_bias[i] = run_sum[i] / samples_taken;
                    run_sum[i] = 0;
                end
                samples_taken = 0;
                r.calib_done  = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            acc_out[i] = 0;
            gyr_out[i] = 0;
            if (i < imuocs_pkg::AXES) begin
                acc_out[i] = (acc[i] - reg_acc_bias[i]) * (longint'(1) << reg_accel_range);
                gyr_out[i] = div_nearest((gyr[i] - gyro_bias[i]) *
                                         (longint'(256) << reg_gyro_range), 131);
            end
        end
        r.accel_x    = imuocs_pkg::ACCEL_W'(acc_out[0]);
        r.accel_y    = imuocs_pkg::ACCEL_W'(acc_out[1]);
        r.accel_z    = imuocs_pkg::ACCEL_W'(acc_out[2]);
        r.gyro_x     = imuocs_pkg::GYRO_W'(gyr_out[0]);
        r.gyro_y     = imuocs_pkg::GYRO_W'(gyr_out[1]);
        r.gyro_z     = imuocs_pkg::GYRO_W'(gyr_out[2]);
        r.temp_centi = imuocs_pkg::TEMP_W'(div_nearest(t_raw * 5, 17) + 3653);
        return r;
    endfunction

    function automatic imu_raw_t make_set(input logic func, input logic [15:0] ax, ay, az,
                                          input logic [15:0] t, gx, gy, gz);
        imu_raw_t r;
        r.func    = func;
        r.accel_x = ax;
        r.accel_y = ay;
        r.accel_z = az;
        r.temp    = t;
        r.gyro_x  = gx;
        r.gyro_y  = gy;
        r.gyro_z  = gz;
        return r;
    endfunction

    // Readings lean toward the rails and toward zero, where wrap and rounding hide.
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return RAW_MIN;
            1:       return RAW_MAX;
            2:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_raw_t random_set(input int calib_pct);
        return make_set(($urandom_range(0, 99) < calib_pct) ? FUNC_CALIBRATE : FUNC_CONVERT,
                        pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                        pick_reading(), pick_reading(), pick_reading());
    endfunction

    // Input driver. A transaction completes at an edge where s_tvalid and s_tready are
    // both high; the expected result is computed right there, with the registers that
    // hold at that moment. A new set is offered only once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scaled_due.push_back(convert_sample(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (raw_sets_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = raw_sets_queued.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.gyro_z, offered.gyro_y, offered.gyro_x, offered.temp,
                                 offered.accel_z, offered.accel_y, offered.accel_x};
                    s_tuser  <= offered.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. Besides random idling it can hold m_tready low for a long
    // stretch on request, counting the cycles itself, so the unit backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stalls_served != stall_requests) begin
            stalls_served <= stall_requests;
            stall_left    <= LONG_STALL;
            m_tready      <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            bad_results++;
        end
    endtask

    // Result monitor: every result transaction is held against the oldest expectation.
    always @(posedge aclk) begin : result_check
        imu_scaled_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (scaled_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                bad_results++;
            end else begin
                want = scaled_due.pop_front();
                check_field("accel_x_scaled", want.accel_x, $signed(m_tdata[19:0]));
                check_field("accel_y_scaled", want.accel_y, $signed(m_tdata[39:20]));
                check_field("accel_z_scaled", want.accel_z, $signed(m_tdata[59:40]));
                check_field("temp_centi", want.temp_centi, $signed(m_tdata[74:60]));
                check_field("gyro_x_scaled", want.gyro_x, $signed(m_tdata[95:75]));
                check_field("gyro_y_scaled", want.gyro_y, $signed(m_tdata[116:96]));
                check_field("gyro_z_scaled", want.gyro_z, $signed(m_tdata[137:117]));
                check_field("tdata padding", 0, m_tdata[143:138]);
                check_field("calib_done", want.calib_done, m_tuser[0]);
            end
        end
    end

    // APB write: setup cycle, access cycle, then the register takes the value at the
    // edge where psel, penable, pwrite and pready are all high.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            imuocs_pkg::REG_GYRO_RANGE:     reg_gyro_range    = int'(value[1:0]);
            imuocs_pkg::REG_ACCEL_RANGE:    reg_accel_range   = int'(value[1:0]);
            imuocs_pkg::REG_CALIB_SAMPLES:  reg_calib_samples = int'(value[7:0]);
            imuocs_pkg::REG_ACCEL_OFFSET_X: reg_acc_bias[0]   = longint'($signed(value[15:0]));
            imuocs_pkg::REG_ACCEL_OFFSET_Y: reg_acc_bias[1]   = longint'($signed(value[15:0]));
            imuocs_pkg::REG_ACCEL_OFFSET_Z: reg_acc_bias[2]   = longint'($signed(value[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_config(input int gr, input int ar, input int cs,
                              input logic [15:0] ox, oy, oz);
        write_reg(imuocs_pkg::REG_GYRO_RANGE, 32'(gr));
        write_reg(imuocs_pkg::REG_ACCEL_RANGE, 32'(ar));
        write_reg(imuocs_pkg::REG_CALIB_SAMPLES, 32'(cs));
        write_reg(imuocs_pkg::REG_ACCEL_OFFSET_X, {{16{ox[15]}}, ox});
        write_reg(imuocs_pkg::REG_ACCEL_OFFSET_Y, {{16{oy[15]}}, oy});
        write_reg(imuocs_pkg::REG_ACCEL_OFFSET_Z, {{16{oz[15]}}, oz});
    endtask

    // Polls at the falling edge so every update of the rising edge has settled. The
    // unit is idle once nothing is queued, nothing is offered and nothing is owed.
    task automatic wait_idle();
        do @(negedge aclk);
        while (raw_sets_queued.size() != 0 || s_tvalid || scaled_due.size() != 0);
        repeat (IDLE_MARGIN) @(negedge aclk);
    endtask

    task automatic queue_random(input int count, input int calib_pct);
        @(negedge aclk);
        repeat (count) raw_sets_queued.push_back(random_set(calib_pct));
    endtask

    initial begin : stimulus
        int          cs;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] oz;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 83;

        // Reset settings: rails and bit patterns, then three calibration samples that
        // stay short of the default count of 64.
        @(negedge aclk);
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, 0, 0, 0, 0, 0, 0, 0));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX,
                                           RAW_MAX, RAW_MAX, RAW_MAX));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN,
                                           RAW_MIN, RAW_MIN, RAW_MIN));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, 16'h5555, 16'hAAAA, 16'h5555,
                                           16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 1, 2, 3, 4, 1000, -2000, 3));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 5, 6, 7, 8, RAW_MIN, RAW_MAX, -1));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 9, 9, 9, 9, 7, 7, -7));
        wait_idle();

        // Widest ranges and accel offsets on the rails. The sample count drops to one
        // while three samples are held, so the next sample finishes with a divisor of
        // four. Gyro offsets are then pushed to each rail and read against the other.
        set_config(3, 3, 1, RAW_MIN, RAW_MAX, 16'h0000);
        @(negedge aclk);
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 0, 0, 0, 0, 100, -100, 0));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, RAW_MAX, RAW_MIN, 12345, RAW_MAX,
                                           RAW_MAX, RAW_MIN, -1));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 0, 0, 0, 0, RAW_MIN, RAW_MIN,
                                           RAW_MIN));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, RAW_MIN, RAW_MAX, RAW_MIN, RAW_MIN,
                                           RAW_MAX, RAW_MAX, RAW_MAX));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 0, 0, 0, 0, RAW_MAX, RAW_MAX,
                                           RAW_MAX));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, 1, -1, 0, 1, RAW_MIN, RAW_MIN,
                                           RAW_MIN));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, -1, 1, 0, -1, 1, -1, 0));
        wait_idle();

        // A sample count of zero must behave as one: every calibration sample finishes.
        set_config(0, 0, 0, 16'h0001, 16'hFFFF, 16'h0000);
        @(negedge aclk);
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 3, -3, 0, 17, -3, 5, -7));
        raw_sets_queued.push_back(make_set(FUNC_CALIBRATE, 0, 0, 0, -17, 66, -65, 131));
        raw_sets_queued.push_back(make_set(FUNC_CONVERT, 0, 0, 0, 0, 65, -66, 0));
        wait_idle();

        // Random phases. The first runs the largest sample count with nearly every set a
        // calibration sample, so a full average of 255 completes; the next drops the count
        // to one with samples still held. The idling pattern changes every few phases.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 83;
            end else if (ph < 6) begin
                send_idle_pct = 83;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            ox = 16'($urandom);
            oy = 16'($urandom);
            oz = 16'($urandom);
            case (ph)
                0: begin
                    cs = 255;
                    ox = RAW_MIN;
                    oy = RAW_MIN;
                    oz = RAW_MIN;
                end
                1: begin
                    cs = 1;
                    ox = RAW_MAX;
                    oy = RAW_MAX;
                    oz = RAW_MAX;
                end
                2:       cs = 0;
                default: cs = $urandom_range(2, 40);
            endcase
            set_config(ph % 4, 3 - ph % 4, cs, ox, oy, oz);
            queue_random((ph == 0) ? 280 : 90, (ph == 0) ? 95 : 50);
            // With the sender never idling, a long receiver hold-off fills the unit and
            // must stall s_tready until results drain again.
            if (ph == 6) stall_requests++;
            wait_idle();
        end

        if (bad_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
